// File: hw/rtl/fhd_pkg.sv
// Shared types and constants for the fire heat diffusion block.
// No dependencies; used by fire_heat_diffusion_unit.
package fhd_pkg;

  localparam int ROW_W  = 7;
  localparam int COL_W  = 8;
  localparam int HEAT_W = 8;
  localparam int SUM_W  = HEAT_W + 2;

  localparam logic CMD_SEED   = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  // result queue
  localparam int QD    = 4;
  localparam int QP_W  = $clog2(QD);
  localparam int QC_W  = $clog2(QD + 1);

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [HEAT_W-1:0] heat;
  } res_t;

endpackage

// File: hw/rtl/fhd_ram.sv
// Generic RAM: one write port, two read ports, registered read data (old data on collision).
// No dependencies.
module fhd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] ra_addr,
  output logic [WIDTH-1:0]         ra_data,
  input  logic [$clog2(DEPTH)-1:0] rb_addr,
  output logic [WIDTH-1:0]         rb_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

// File: hw/rtl/fire_heat_diffusion_unit.sv
// Fire heat diffusion top level: heat grid in two mirrored RAMs, pipelined read-modify-write.
// Depends on fhd_pkg and fhd_ram.
//
//   channel | handshake            | payload
//   in      | in_valid / in_ready  | cmd, source_row, column, seed_heat
//   out     | out_valid / out_ready| target_row, target_column, new_heat
//
// One item per cycle while out_ready stays high; results pass stages 1, 2 and the result queue.
// Throughput is set by the four grid reads per update: two mirrored RAMs with two read ports each.
// After reset the grid is swept to zero, all (ROWS+1)*COLS entries (16160 by default), in_ready low.
// The bottom two rows always hold the same values, so only one of them is stored.
// Results queue in a 4-entry buffer; in_ready drops when queue plus in-flight items reach 4.
module fire_heat_diffusion_unit #(
  parameter int COLS = 160,
  parameter int ROWS = 100
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        cmd,
  input  logic [fhd_pkg::ROW_W-1:0]   source_row,
  input  logic [fhd_pkg::COL_W-1:0]   column,
  input  logic [fhd_pkg::HEAT_W-1:0]  seed_heat,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [fhd_pkg::ROW_W-1:0]   target_row,
  output logic [fhd_pkg::COL_W-1:0]   target_column,
  output logic [fhd_pkg::HEAT_W-1:0]  new_heat
);

  localparam int DEPTH = (ROWS + 1) * COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int LAW   = $clog2((ROWS + 2) * COLS + 1);
  localparam int NW    = 11;
  localparam int CRW   = fhd_pkg::QC_W + 1;

  // clearing sweep
  logic [AW-1:0] clr_addr;
  logic          clr_done;

  // stage 1
  logic                        s1_valid;
  logic                        s1_cmd;
  logic [fhd_pkg::ROW_W-1:0]   s1_row;
  logic [fhd_pkg::COL_W-1:0]   s1_col;
  logic [fhd_pkg::HEAT_W-1:0]  s1_seed;
  logic [LAW-1:0]              s1_addr;

  // stage 2
  logic                        s2_valid;
  logic                        s2_cmd;
  logic [fhd_pkg::ROW_W-1:0]   s2_row;
  logic [fhd_pkg::COL_W-1:0]   s2_col;
  logic [fhd_pkg::HEAT_W-1:0]  s2_seed;
  logic [AW-1:0]               s2_waddr;
  logic [AW-1:0]               s2_ra [4];

  // last write, for forwarding
  logic                        pw_valid;
  logic [AW-1:0]               pw_addr;
  logic [fhd_pkg::HEAT_W-1:0]  pw_data;

  // result queue
  fhd_pkg::res_t               q [fhd_pkg::QD];
  logic [fhd_pkg::QP_W-1:0]    q_wr;
  logic [fhd_pkg::QP_W-1:0]    q_rd;
  logic [fhd_pkg::QC_W-1:0]    q_cnt;

  logic                        accept;
  logic                        keep;
  logic                        pop;
  logic [LAW-1:0]              a_next;
  logic [LAW-1:0]              rd_next [4];
  logic [LAW-1:0]              wr_next;
  logic [fhd_pkg::HEAT_W-1:0]  rdata [4];
  logic [fhd_pkg::HEAT_W-1:0]  fwd [4];
  logic [fhd_pkg::SUM_W-1:0]   sum;
  logic [fhd_pkg::HEAT_W-1:0]  avg;
  logic [fhd_pkg::HEAT_W-1:0]  heat;
  fhd_pkg::res_t               res;
  logic                        we;
  logic [AW-1:0]               waddr;
  logic [fhd_pkg::HEAT_W-1:0]  wdata;

  assign in_ready = clr_done &&
    ((CRW'(q_cnt) + CRW'(s1_valid) + CRW'(s2_valid)) < CRW'(fhd_pkg::QD));
  assign accept   = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  always_comb begin
    keep = (NW'(column) < NW'(COLS));
    if (cmd == fhd_pkg::CMD_UPDATE) begin
      keep = keep && (source_row != '0) && (NW'(source_row) <= NW'(ROWS));
      a_next = LAW'(source_row) * LAW'(COLS) + LAW'(column);
    end else begin
      a_next = LAW'(ROWS * COLS) + LAW'(column);
    end
  end

  // read addresses; the row below the bottom row mirrors it
  always_comb begin
    rd_next[0] = s1_addr - LAW'(1);
    rd_next[1] = s1_addr;
    rd_next[2] = s1_addr + LAW'(1);
    if (rd_next[2] == LAW'(DEPTH)) begin
      rd_next[2] = LAW'(DEPTH - COLS);
    end
    rd_next[3] = (NW'(s1_row) == NW'(ROWS)) ? s1_addr : s1_addr + LAW'(COLS);
    wr_next    = (s1_cmd == fhd_pkg::CMD_UPDATE) ? s1_addr - LAW'(COLS) : s1_addr;
  end

  fhd_ram #(.WIDTH(fhd_pkg::HEAT_W), .DEPTH(DEPTH)) u_ram_a (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .ra_addr (AW'(rd_next[0])),
    .ra_data (rdata[0]),
    .rb_addr (AW'(rd_next[1])),
    .rb_data (rdata[1])
  );

  fhd_ram #(.WIDTH(fhd_pkg::HEAT_W), .DEPTH(DEPTH)) u_ram_b (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .ra_addr (AW'(rd_next[2])),
    .ra_data (rdata[2]),
    .rb_addr (AW'(rd_next[3])),
    .rb_data (rdata[3])
  );

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      fwd[k] = (pw_valid && pw_addr == s2_ra[k]) ? pw_data : rdata[k];
    end
    sum = fhd_pkg::SUM_W'(fwd[0]) + fhd_pkg::SUM_W'(fwd[1]) +
          fhd_pkg::SUM_W'(fwd[2]) + fhd_pkg::SUM_W'(fwd[3]);
    avg = sum[fhd_pkg::SUM_W-1:2];
    if (s2_cmd == fhd_pkg::CMD_UPDATE) begin
      heat    = (avg != '0) ? avg - fhd_pkg::HEAT_W'(1) : '0;
      res.row = s2_row - fhd_pkg::ROW_W'(1);
    end else begin
      heat    = s2_seed;
      res.row = fhd_pkg::ROW_W'(ROWS);
    end
    res.col  = s2_col;
    res.heat = heat;
  end

  assign we    = s2_valid || !clr_done;
  assign waddr = clr_done ? s2_waddr : clr_addr;
  assign wdata = clr_done ? heat : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      clr_done <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      pw_valid <= 1'b0;
      q_wr     <= '0;
      q_rd     <= '0;
      q_cnt    <= '0;
    end else begin
      if (!clr_done) begin
        clr_addr <= clr_addr + AW'(1);
        if (clr_addr == AW'(DEPTH - 1)) begin
          clr_done <= 1'b1;
        end
      end
      s1_valid <= accept && keep;
      s2_valid <= s1_valid;
      pw_valid <= s2_valid;
      if (s2_valid) begin
        q_wr <= q_wr + fhd_pkg::QP_W'(1);
      end
      if (pop) begin
        q_rd <= q_rd + fhd_pkg::QP_W'(1);
      end
      q_cnt <= q_cnt + fhd_pkg::QC_W'(s2_valid) - fhd_pkg::QC_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    s1_cmd   <= cmd;
    s1_row   <= source_row;
    s1_col   <= column;
    s1_seed  <= seed_heat;
    s1_addr  <= a_next;
    s2_cmd   <= s1_cmd;
    s2_row   <= s1_row;
    s2_col   <= s1_col;
    s2_seed  <= s1_seed;
    s2_waddr <= AW'(wr_next);
    for (int k = 0; k < 4; k++) begin
      s2_ra[k] <= AW'(rd_next[k]);
    end
    pw_addr  <= s2_waddr;
    pw_data  <= heat;
    if (s2_valid) begin
      q[q_wr] <= res;
    end
  end

  assign out_valid     = (q_cnt != '0);
  assign target_row    = q[q_rd].row;
  assign target_column = q[q_rd].col;
  assign new_heat      = q[q_rd].heat;

  a_accept_after_clear: assert property (@(posedge clk) disable iff (rst)
    accept |-> clr_done) else $error("item accepted during clearing sweep");

  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> (q_cnt < fhd_pkg::QC_W'(fhd_pkg::QD)))
    else $error("result pushed into full queue");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_cnt <= fhd_pkg::QC_W'(fhd_pkg::QD)) else $error("result queue overflow");

  a_write_range: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && clr_done) |-> (LAW'(s2_waddr) < LAW'(DEPTH - COLS) ||
                                LAW'(s2_waddr) == LAW'(DEPTH - COLS) + LAW'(s2_col)))
    else $error("grid write outside rows 0..ROWS");

  a_fwd_after_clear: assert property (@(posedge clk) disable iff (rst)
    pw_valid |-> $past(clr_done)) else $error("forwarded write overlaps clearing");

endmodule

// File: tb/fhd_grid_checker.sv
`timescale 1ns / 1ps
// Heat grid checker: watches both channels, keeps its own copy of the heat grid,
// predicts the written cell for every accepted item that lands and compares results. Uses fhd_pkg.
module fhd_grid_checker #(
  parameter int COLS = 160,
  parameter int ROWS = 100
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic                        cmd,
  input  logic [fhd_pkg::ROW_W-1:0]   source_row,
  input  logic [fhd_pkg::COL_W-1:0]   column,
  input  logic [fhd_pkg::HEAT_W-1:0]  seed_heat,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [fhd_pkg::ROW_W-1:0]   target_row,
  input  logic [fhd_pkg::COL_W-1:0]   target_column,
  input  logic [fhd_pkg::HEAT_W-1:0]  new_heat,
  output int                          fail_count,
  output int                          pending
);

  localparam int CELLS = (ROWS + 2) * COLS;

  logic [fhd_pkg::HEAT_W-1:0] heat_grid [CELLS];
  fhd_pkg::res_t              written_cells [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic int grid_at(input int addr);
    if (addr < 0 || addr >= CELLS) return 0;
    return int'(heat_grid[addr]);
  endfunction

  // Applies one item to the grid copy; returns 1 with the written cell if it lands.
  function automatic bit seed_or_diffuse(input logic c, input logic [fhd_pkg::ROW_W-1:0] r,
                                         input logic [fhd_pkg::COL_W-1:0] col,
                                         input logic [fhd_pkg::HEAT_W-1:0] h,
                                         output fhd_pkg::res_t hit);
    int                         addr;
    int                         total;
    logic [fhd_pkg::HEAT_W-1:0] heat;
    hit = '0;
    if (int'(col) >= COLS) return 1'b0;
    if (c == fhd_pkg::CMD_SEED) begin
      heat_grid[ROWS * COLS + int'(col)]       = h;
      heat_grid[(ROWS + 1) * COLS + int'(col)] = h;
      hit.row  = fhd_pkg::ROW_W'(ROWS);
      hit.col  = col;
      hit.heat = h;
      return 1'b1;
    end
    if (r < 1 || int'(r) > ROWS) return 1'b0;
    addr  = int'(r) * COLS + int'(col);
    total = grid_at(addr - 1) + grid_at(addr) + grid_at(addr + 1) + grid_at(addr + COLS);
    total = total >> 2;
    if (total != 0) total = total - 1;
    heat = fhd_pkg::HEAT_W'(total);
    heat_grid[addr - COLS] = heat;
    hit.row  = r - fhd_pkg::ROW_W'(1);
    hit.col  = col;
    hit.heat = heat;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    fhd_pkg::res_t want, got, hit;
    if (rst) begin
      for (int i = 0; i < CELLS; i++) heat_grid[i] = '0;
      written_cells.delete();
    end else begin
      if (out_valid && out_ready) begin
        got.row  = target_row;
        got.col  = target_column;
        got.heat = new_heat;
        if (written_cells.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected item: row %0d col %0d heat %0d",
                     got.row, got.col, got.heat);
        end else begin
          want = written_cells.pop_front();
          if (want.row != got.row || want.col != got.col || want.heat != got.heat) begin
            fail_count++;
            if (fail_count <= 10)
              $display("cell mismatch: exp row %0d col %0d heat %0d,",
                       want.row, want.col, want.heat,
                       " got row %0d col %0d heat %0d", got.row, got.col, got.heat);
          end
        end
      end
      if (in_valid && in_ready &&
          seed_or_diffuse(cmd, source_row, column, seed_heat, hit))
        written_cells.push_back(hit);
    end
    pending = written_cells.size();
  end

endmodule

// File: tb/fire_heat_diffusion_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for fire_heat_diffusion_unit: drives directed and random seed/update items,
// random idling and a long receiver hold; depends on fhd_pkg and fhd_grid_checker.
module fire_heat_diffusion_unit_tb;

  localparam int COLS         = 160;
  localparam int ROWS         = 100;
  localparam int RANDOM_ITEMS = 450;
  localparam int IDLE_LIMIT   = 80000;
  localparam int HOLD_CYCLES  = 300;

  logic                       clk        = 1'b0;
  logic                       rst        = 1'b1;
  logic                       in_valid   = 1'b0;
  logic                       in_ready;
  logic                       cmd        = fhd_pkg::CMD_SEED;
  logic [fhd_pkg::ROW_W-1:0]  source_row = '0;
  logic [fhd_pkg::COL_W-1:0]  column     = '0;
  logic [fhd_pkg::HEAT_W-1:0] seed_heat  = '0;
  logic                       out_valid;
  logic                       out_ready  = 1'b0;
  logic [fhd_pkg::ROW_W-1:0]  target_row;
  logic [fhd_pkg::COL_W-1:0]  target_column;
  logic [fhd_pkg::HEAT_W-1:0] new_heat;

  bit steady   = 1'b0;
  bit hold_req = 1'b0;
  int fails;
  int pending;

  always #1 clk = ~clk;

  fire_heat_diffusion_unit #(.COLS(COLS), .ROWS(ROWS)) u_dut (
    .clk, .rst, .in_valid, .in_ready, .cmd, .source_row, .column, .seed_heat,
    .out_valid, .out_ready, .target_row, .target_column, .new_heat
  );

  fhd_grid_checker #(.COLS(COLS), .ROWS(ROWS)) u_checker (
    .clk, .rst, .in_valid, .in_ready, .cmd, .source_row, .column, .seed_heat,
    .out_valid, .out_ready, .target_row, .target_column, .new_heat,
    .fail_count(fails), .pending(pending)
  );

  function automatic bit lands(input logic c, input logic [fhd_pkg::ROW_W-1:0] r,
                               input logic [fhd_pkg::COL_W-1:0] col);
    return int'(col) < COLS && (c == fhd_pkg::CMD_SEED || (r >= 1 && int'(r) <= ROWS));
  endfunction

  task automatic send_item(input logic c, input logic [fhd_pkg::ROW_W-1:0] r,
                           input logic [fhd_pkg::COL_W-1:0] col,
                           input logic [fhd_pkg::HEAT_W-1:0] h);
    while (!steady && $urandom_range(99) < 10) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    cmd        = c;
    source_row = r;
    column     = col;
    seed_heat  = h;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // receiver
  initial begin
    bit held;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        held      = 1'b1;
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready = steady || ($urandom_range(99) >= 10);
    end
  end

  // watchdog
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int landed, pick, run, start;
    logic [fhd_pkg::ROW_W-1:0] r;
    logic [fhd_pkg::COL_W-1:0] col;
    logic                      c;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // bottom-row seeds at the edges and alternating bit patterns
    send_item(fhd_pkg::CMD_SEED, 7'h7F, 8'd0, 8'd255);
    send_item(fhd_pkg::CMD_SEED, 7'd0, 8'd1, 8'd255);
    send_item(fhd_pkg::CMD_SEED, 7'd0, 8'd159, 8'd255);
    send_item(fhd_pkg::CMD_SEED, 7'd0, 8'd158, 8'd255);
    send_item(fhd_pkg::CMD_SEED, 7'd0, 8'd80, 8'hAA);
    send_item(fhd_pkg::CMD_SEED, 7'd0, 8'd81, 8'h55);
    // wrap to the row before, wrap to the next row, maximum sum
    send_item(fhd_pkg::CMD_UPDATE, 7'd100, 8'd0, 8'hFF);
    send_item(fhd_pkg::CMD_UPDATE, 7'd100, 8'd159, 8'h00);
    send_item(fhd_pkg::CMD_UPDATE, 7'd100, 8'd1, 8'h00);
    send_item(fhd_pkg::CMD_UPDATE, 7'd99, 8'd0, 8'h00);
    send_item(fhd_pkg::CMD_UPDATE, 7'd100, 8'd80, 8'h00);
    // top source row and zero heat
    send_item(fhd_pkg::CMD_UPDATE, 7'd1, 8'd0, 8'h00);
    send_item(fhd_pkg::CMD_UPDATE, 7'd1, 8'd159, 8'h00);
    send_item(fhd_pkg::CMD_UPDATE, 7'd50, 8'd5, 8'h00);
    send_item(fhd_pkg::CMD_SEED, 7'd0, 8'd0, 8'd0);
    send_item(fhd_pkg::CMD_UPDATE, 7'd100, 8'd0, 8'h00);
    // items the block drops
    send_item(fhd_pkg::CMD_UPDATE, 7'd0, 8'd5, 8'h00);
    send_item(fhd_pkg::CMD_UPDATE, 7'd101, 8'd5, 8'h00);
    send_item(fhd_pkg::CMD_UPDATE, 7'h7F, 8'hFF, 8'hFF);
    send_item(fhd_pkg::CMD_SEED, 7'd0, 8'd160, 8'd7);
    send_item(fhd_pkg::CMD_SEED, 7'd0, 8'hFF, 8'hFF);
    send_item(fhd_pkg::CMD_UPDATE, 7'd50, 8'd200, 8'h00);

    landed = 0;
    while (landed < RANDOM_ITEMS) begin
      steady = (landed >= 120 && landed < 220);
      if (landed >= 300) hold_req = 1'b1;
      pick = $urandom_range(99);
      if (pick < 8) begin
        c = 1'($urandom_range(1));
        if ($urandom_range(1)) begin
          r   = $urandom_range(1) ? 7'd0 :
                fhd_pkg::ROW_W'($urandom_range(127, ROWS + 1));
          col = fhd_pkg::COL_W'($urandom);
        end else begin
          r   = fhd_pkg::ROW_W'($urandom);
          col = fhd_pkg::COL_W'($urandom_range(255, COLS));
        end
        send_item(c, r, col, fhd_pkg::HEAT_W'($urandom));
        if (lands(c, r, col)) landed++;
      end else if (pick < 25) begin
        send_item(fhd_pkg::CMD_SEED, fhd_pkg::ROW_W'($urandom),
                  fhd_pkg::COL_W'($urandom_range(COLS - 1)), fhd_pkg::HEAT_W'($urandom));
        landed++;
      end else begin
        // short raster run along one row
        r     = (pick < 70) ? fhd_pkg::ROW_W'($urandom_range(ROWS, ROWS - 10)) :
                              fhd_pkg::ROW_W'($urandom_range(ROWS, 1));
        start = $urandom_range(COLS - 1);
        run   = $urandom_range(16, 1);
        for (int k = 0; k < run && start + k < COLS; k++) begin
          send_item(fhd_pkg::CMD_UPDATE, r, fhd_pkg::COL_W'(start + k),
                    fhd_pkg::HEAT_W'($urandom));
          landed++;
        end
      end
    end
    in_valid = 1'b0;
    steady   = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (fails == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
